// File: rtl/cfec_pkg.sv
// ----------------------------------------------------------------------------
// cfec_pkg
// shared types and constants of the can frame event classifier
// ----------------------------------------------------------------------------
`default_nettype none
package cfec_pkg;

    localparam int NodeCountDefault = 16;
    localparam int NodeW = 4;

    localparam logic [10:0] GrpFirstCmd  = 11'h640;
    localparam logic [10:0] GrpFirstRep  = 11'h5C0;
    localparam logic [10:0] GrpThird     = 11'h140;
    localparam logic [10:0] GrpMask      = 11'h7F0;
    localparam logic [10:0] IdCylCmd     = 11'h003;
    localparam logic [10:0] IdCylRep     = 11'h103;
    localparam logic [10:0] IdEstop      = 11'h7FF;

    localparam logic [7:0] CmdSetPos     = 8'h86;
    localparam logic [7:0] CmdStart      = 8'h83;
    localparam logic [7:0] CmdStop       = 8'h84;
    localparam logic [7:0] CmdEnable     = 8'h01;
    localparam logic [7:0] RepPosMark    = 8'h3E;
    localparam logic [7:0] CylWrite      = 8'h1A;
    localparam logic [7:0] CylWriteSub   = 8'h05;
    localparam logic [7:0] CylEnable     = 8'h00;
    localparam logic [7:0] CylFeedback   = 8'h2B;
    localparam logic [7:0] CylAck        = 8'h1B;
    localparam logic [7:0] ThSet         = 8'hA4;
    localparam logic [7:0] ThResp        = 8'h92;
    localparam logic [7:0] ThEnable      = 8'h88;

    localparam logic [1:0] RegStale = 2'd0;
    localparam logic [1:0] RegEcho  = 2'd1;
    localparam logic [1:0] RegLimit = 2'd2;

    typedef enum logic [3:0] {
        EV_NONE = 4'd0, EV_SET_POS = 4'd1, EV_START = 4'd2, EV_STOP = 4'd3,
        EV_ENABLE = 4'd4, EV_FEEDBACK = 4'd5, EV_CYL_WRITE = 4'd6,
        EV_CYL_ENABLE = 4'd7, EV_CYL_FEEDBACK = 4'd8, EV_CYL_UNEXPECTED = 4'd9,
        EV_RMD_SET = 4'd10, EV_RMD_ENABLE = 4'd11, EV_ESTOP = 4'd12,
        EV_UNKNOWN = 4'd13
    } event_t;

    // frame classes decided by the front part
    typedef enum logic [2:0] {
        CL_IGNORE, CL_FIRST_CMD, CL_FIRST_REP, CL_CYL_CMD, CL_CYL_REP,
        CL_THIRD, CL_ESTOP, CL_UNKNOWN
    } class_t;

    typedef struct packed {
        class_t      cls;
        logic [3:0]  node;
        logic [10:0] can_id;
        logic [3:0]  len;
        logic [63:0] data;
        logic [31:0] ts;
    } item_t;

    function automatic logic [7:0] byte_at(input logic [63:0] d, input int i);
        return d[63-8*i -: 8];
    endfunction

endpackage
`default_nettype wire

// File: rtl/cfec_front.sv
// ----------------------------------------------------------------------------
// cfec_front
// accepts frames, sorts them by identifier into a class, registers the beat
// ----------------------------------------------------------------------------
`default_nettype none
module cfec_front #(
    parameter int NODE_COUNT = cfec_pkg::NodeCountDefault
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [10:0]     can_id,
    input  wire logic [3:0]      frame_length,
    input  wire logic [63:0]     data_bytes,
    input  wire logic [31:0]     timestamp_us,
    output logic                 q_valid,
    input  wire logic            q_ready,
    output cfec_pkg::item_t      q_item
);
    import cfec_pkg::*;

    logic   valid_reg;
    item_t  item_reg;
    item_t  item_next;
    logic [10:0] grp;
    logic   node_ok;

    assign in_ready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;

    // classify by identifier
    always_comb
    begin
        grp       = can_id & GrpMask;
        node_ok   = ({1'b0, can_id[3:0]} < 5'(NODE_COUNT));
        item_next.node   = can_id[3:0];
        item_next.can_id = can_id;
        item_next.len    = (frame_length > 4'd8) ? 4'd8 : frame_length;
        item_next.data   = data_bytes;
        item_next.ts     = timestamp_us;
        if (grp == GrpFirstCmd)
            item_next.cls = node_ok ? CL_FIRST_CMD : CL_IGNORE;
        else if (grp == GrpFirstRep)
            item_next.cls = node_ok ? CL_FIRST_REP : CL_IGNORE;
        else if (can_id == IdCylCmd)
            item_next.cls = CL_CYL_CMD;
        else if (can_id == IdCylRep)
            item_next.cls = CL_CYL_REP;
        else if (grp == GrpThird)
            item_next.cls = node_ok ? CL_THIRD : CL_IGNORE;
        else if (can_id == IdEstop)
            item_next.cls = CL_ESTOP;
        else
            item_next.cls = CL_UNKNOWN;
    end

    // stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

endmodule
`default_nettype wire

// File: rtl/cfec_back.sv
// ----------------------------------------------------------------------------
// cfec_back
// per-node tables, event decision and output register
// ----------------------------------------------------------------------------
`default_nettype none
module cfec_back #(
    parameter int NODE_COUNT = cfec_pkg::NodeCountDefault
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_idx,
    input  wire logic [19:0]        cfg_data,
    input  wire logic               q_valid,
    output logic                    q_ready,
    input  wire cfec_pkg::item_t    q_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [3:0]              event_code,
    output logic [3:0]              node,
    output logic signed [31:0]      value,
    output logic signed [31:0]      delta,
    output logic                    stale_response
);
    import cfec_pkg::*;

    localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    logic [19:0] stale_win_reg, echo_win_reg;
    logic [2:0]  limit_reg, unk_reg;

    logic [31:0] fc_pos_reg   [NODE_COUNT];
    logic [NODE_COUNT-1:0] fc_val_reg, fr_val_reg;
    logic [31:0] fr_pos_reg   [NODE_COUNT];
    logic [31:0] fc_time_reg  [NODE_COUNT];
    logic [31:0] th_time_reg  [NODE_COUNT];
    logic [31:0] th_bal_reg   [NODE_COUNT];
    logic [31:0] th_set_reg   [NODE_COUNT];
    logic [31:0] cyl_wr_reg, cyl_rp_reg;
    logic        cyl_rv_reg;

    logic        ov_reg;
    logic [3:0]  ev_reg, node_reg;
    logic [31:0] val_reg, dlt_reg;
    logic        stale_reg;

    logic        take;
    logic [NW-1:0] n;
    logic [7:0]  b0, b1, b3, b4, b5;
    logic [31:0] p_be2, p_be0, p_cyl, a_le;
    logic [32:0] stale_lim;
    logic [32:0] gap;
    logic        pending, resp;

    logic [3:0]  ev;
    logic [31:0] val, dlt;
    logic        stl;
    logic        wr_fc, wr_fr, wr_fct, wr_cw, wr_cr, wr_tt, wr_ts, unk_inc;
    logic [31:0] bal_new;
    logic        wr_bal;

    assign q_ready    = !ov_reg || out_ready;
    assign take       = q_valid && q_ready;
    assign out_valid  = ov_reg;
    assign event_code = ev_reg;
    assign node       = node_reg;
    assign value      = val_reg;
    assign delta      = dlt_reg;
    assign stale_response = stale_reg;

    // field extraction and window checks
    always_comb
    begin
        n     = q_item.node[NW-1:0];
        b0    = byte_at(q_item.data, 0);
        b1    = byte_at(q_item.data, 1);
        b3    = byte_at(q_item.data, 3);
        b4    = byte_at(q_item.data, 4);
        b5    = byte_at(q_item.data, 5);
        p_be2 = q_item.data[47:16];
        p_be0 = q_item.data[63:32];
        p_cyl = {q_item.data[39:24], q_item.data[15:0]};
        a_le  = {byte_at(q_item.data, 6), b5, b4, b3};
        stale_lim = {1'b0, fc_time_reg[n]} + {13'd0, stale_win_reg};
        gap   = {1'b0, q_item.ts} - {1'b0, th_time_reg[n]};
        pending = !th_bal_reg[n][31] && (th_bal_reg[n] != 32'd0);
        // signed gap below window: negative gap or small positive
        resp  = (th_time_reg[n] != 32'd0) && pending &&
                (gap[32] || (gap[31:0] < {12'd0, echo_win_reg}));
    end

    // event decision
    always_comb
    begin
        ev = EV_NONE; val = 32'd0; dlt = 32'd0; stl = 1'b0;
        wr_fc = 1'b0; wr_fr = 1'b0; wr_fct = 1'b0; wr_cw = 1'b0; wr_cr = 1'b0;
        wr_tt = 1'b0; wr_ts = 1'b0; unk_inc = 1'b0; wr_bal = 1'b0;
        bal_new = th_bal_reg[n];
        case (q_item.cls)
            CL_FIRST_CMD:
            begin
                wr_fct = 1'b1;
                if (q_item.len >= 4'd2)
                begin
                    if (b1 == CmdSetPos && q_item.len >= 4'd6)
                    begin
                        if (!fc_val_reg[n] || p_be2 != fc_pos_reg[n])
                        begin
                            ev = EV_SET_POS; val = p_be2; wr_fc = 1'b1;
                            dlt = fc_val_reg[n] ? p_be2 - fc_pos_reg[n] : 32'd0;
                        end
                    end
                    else if (b1 == CmdStart)
                        ev = EV_START;
                    else if (b1 == CmdStop)
                        ev = EV_STOP;
                    else if (b1 == CmdEnable && q_item.len >= 4'd6)
                    begin
                        ev = EV_ENABLE; val = {24'd0, b5};
                    end
                end
            end
            CL_FIRST_REP:
            begin
                if (q_item.len >= 4'd5 && b4 == RepPosMark &&
                    (!fr_val_reg[n] || p_be0 != fr_pos_reg[n]))
                begin
                    ev = EV_FEEDBACK; val = p_be0; wr_fr = 1'b1;
                    dlt = fr_val_reg[n] ? p_be0 - fr_pos_reg[n] : 32'd0;
                end
                stl = ({1'b0, q_item.ts} > stale_lim);
            end
            CL_CYL_CMD:
            begin
                if (q_item.len >= 4'd2)
                begin
                    if (b1 == CylWrite)
                    begin
                        if (q_item.len >= 4'd8 && b5 == CylWriteSub &&
                            p_cyl != cyl_wr_reg)
                        begin
                            ev = EV_CYL_WRITE; val = p_cyl; wr_cw = 1'b1;
                            dlt = p_cyl - cyl_wr_reg;
                        end
                    end
                    else if (b1 == CylEnable && q_item.len >= 4'd5)
                    begin
                        ev = EV_CYL_ENABLE; val = {16'd0, b3, b4};
                    end
                end
            end
            CL_CYL_REP:
            begin
                if (q_item.len >= 4'd2)
                begin
                    if (b1 == CylFeedback)
                    begin
                        if (q_item.len >= 4'd8 &&
                            (!cyl_rv_reg || p_cyl != cyl_rp_reg))
                        begin
                            ev = EV_CYL_FEEDBACK; val = p_cyl; wr_cr = 1'b1;
                            dlt = cyl_rv_reg ? p_cyl - cyl_rp_reg : 32'd0;
                        end
                    end
                    else if (b1 != CylAck)
                    begin
                        ev = EV_CYL_UNEXPECTED; val = {24'd0, b1};
                    end
                end
            end
            CL_THIRD:
            begin
                if (q_item.len >= 4'd1)
                begin
                    if (b0 == ThSet && q_item.len >= 4'd7)
                    begin
                        wr_bal = 1'b1;
                        if (!resp)
                        begin
                            bal_new = th_bal_reg[n] + 32'd1; wr_tt = 1'b1;
                            if (a_le != th_set_reg[n])
                            begin
                                ev = EV_RMD_SET; val = a_le; wr_ts = 1'b1;
                                dlt = a_le - th_set_reg[n];
                            end
                        end
                        else
                            bal_new = th_bal_reg[n] - 32'd1;
                    end
                    else if (b0 == ThResp)
                    begin
                        wr_bal = 1'b1; bal_new = th_bal_reg[n] - 32'd1;
                    end
                    else if (b0 == ThEnable)
                    begin
                        ev = EV_RMD_ENABLE; wr_bal = 1'b1; wr_tt = 1'b1;
                        bal_new = th_bal_reg[n] + 32'd1;
                    end
                end
            end
            CL_ESTOP:
                ev = EV_ESTOP;
            CL_UNKNOWN:
            begin
                unk_inc = 1'b1;
                if (unk_reg < limit_reg)
                begin
                    ev = EV_UNKNOWN; val = {21'd0, q_item.can_id};
                end
            end
            default:
                ev = EV_NONE;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_win_reg <= 20'd10000;
            echo_win_reg  <= 20'd5000;
            limit_reg     <= 3'd5;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                RegStale: stale_win_reg <= cfg_data;
                RegEcho:  echo_win_reg  <= cfg_data;
                RegLimit: limit_reg     <= cfg_data[2:0];
                default:  limit_reg     <= limit_reg;
            endcase
        end
    end

    // state tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_val_reg <= '0; fr_val_reg <= '0; cyl_rv_reg <= 1'b0;
            cyl_wr_reg <= '0; cyl_rp_reg <= '0; unk_reg <= '0;
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                fc_pos_reg[i] <= '0; fr_pos_reg[i] <= '0; fc_time_reg[i] <= '0;
                th_time_reg[i] <= '0; th_bal_reg[i] <= '0; th_set_reg[i] <= '0;
            end
        end
        else if (take)
        begin
            if (wr_fc) begin fc_pos_reg[n] <= p_be2; fc_val_reg[n] <= 1'b1; end
            if (wr_fr) begin fr_pos_reg[n] <= p_be0; fr_val_reg[n] <= 1'b1; end
            if (wr_fct) fc_time_reg[n] <= q_item.ts;
            if (wr_cw) cyl_wr_reg <= p_cyl;
            if (wr_cr) begin cyl_rp_reg <= p_cyl; cyl_rv_reg <= 1'b1; end
            if (wr_tt) th_time_reg[n] <= q_item.ts;
            if (wr_ts) th_set_reg[n] <= a_le;
            if (wr_bal) th_bal_reg[n] <= bal_new;
            if (unk_inc && unk_reg != 3'd7) unk_reg <= unk_reg + 3'd1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (q_ready)
            ov_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ev_reg <= ev; node_reg <= (q_item.cls == CL_FIRST_CMD ||
                q_item.cls == CL_FIRST_REP || q_item.cls == CL_THIRD) ?
                q_item.node : 4'd0;
            val_reg <= val; dlt_reg <= dlt; stale_reg <= stl;
        end
    end

endmodule
`default_nettype wire

// File: rtl/can_frame_event_classifier_core.sv
// ----------------------------------------------------------------------------
// can_frame_event_classifier_core
// classifies can frames into actuator events with per-node tracking
// ----------------------------------------------------------------------------
// in channel: in_valid/in_ready with can_id, frame_length, data_bytes,
// timestamp_us. out channel: out_valid/out_ready with event_code, node,
// value, delta, stale_response; every frame gives exactly one result beat.
// configuration: cfg_we, cfg_idx, cfg_data; 0 stale window, 1 echo window,
// 2 unknown report limit; write only while idle.
// from accept to result valid a frame passes the front classifier register,
// then the back table update and output register.
// throughput is one frame per cycle while out_ready holds; tables are
// written when a frame is taken, so it sees every earlier frame's writes.
// reset clears all tables, valid flags and the unknown counter and loads
// the window defaults. a stalled receiver holds the output register; the
// front register then fills and in_ready drops until out_ready returns.
`default_nettype none
module can_frame_event_classifier_core #(
    parameter int NODE_COUNT = cfec_pkg::NodeCountDefault
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_idx,
    input  wire logic [19:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [10:0]        can_id,
    input  wire logic [3:0]         frame_length,
    input  wire logic [63:0]        data_bytes,
    input  wire logic [31:0]        timestamp_us,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [3:0]              event_code,
    output logic [3:0]              node,
    output logic signed [31:0]      value,
    output logic signed [31:0]      delta,
    output logic                    stale_response
);
    import cfec_pkg::*;

    logic  q_valid, q_ready;
    item_t q_item;

    // front classifier
    cfec_front #(.NODE_COUNT(NODE_COUNT)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .can_id, .frame_length,
        .data_bytes, .timestamp_us, .q_valid, .q_ready, .q_item
    );

    // back state and output
    cfec_back #(.NODE_COUNT(NODE_COUNT)) u_back (
        .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data, .q_valid, .q_ready,
        .q_item, .out_valid, .out_ready, .event_code, .node, .value, .delta,
        .stale_response
    );

endmodule
`default_nettype wire

// File: rtl/cfec_checker.sv
// ----------------------------------------------------------------------------
// cfec_checker
// port level checks of the classifier core
// ----------------------------------------------------------------------------
`default_nettype none
module cfec_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [3:0]  event_code,
    input wire logic [3:0]  node,
    input wire logic [31:0] delta,
    input wire logic        stale_response
);
    import cfec_pkg::*;

    // result beat held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_code))
        else $error("result changed while stalled");

    // stale flag only with no event or feedback
    a_stale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stale_response |->
        (event_code == EV_NONE || event_code == EV_FEEDBACK))
        else $error("stale flag on wrong event");

    // non-tracked events carry no delta
    a_delta: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code == EV_ESTOP || event_code == EV_UNKNOWN ||
        event_code == EV_START) |-> delta == 32'd0 && (event_code == EV_START
        || node == 4'd0))
        else $error("unexpected delta or node");

    // accepted frame shows as result later
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_ready |=> ##1 out_valid)
        else $error("accepted frame lost");

endmodule

bind can_frame_event_classifier_core cfec_checker u_cfec_checker (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .event_code, .node, .delta, .stale_response
);
`default_nettype wire

// File: dv/can_frame_event_classifier_core_test.sv
// ----------------------------------------------------------------------------
// can_frame_event_classifier_core_test
// self-checking bench: directed and random can frames are pushed through the
// classifier, expected events come from a predictor with its own node tables,
// and every output beat is compared in order against them
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

// expected event of one frame
typedef struct packed {
    logic [3:0]  code;
    logic [3:0]  node;
    logic [31:0] value;
    logic [31:0] delta;
    logic        stale;
} frame_event_t;

// holds classifier state and compares output beats
class frame_event_board;
    logic [19:0] stale_win;
    logic [19:0] echo_win;
    logic [2:0]  unk_limit;
    logic [31:0] cmd_pos [16];
    bit          cmd_ok [16];
    logic [31:0] rep_pos [16];
    bit          rep_ok [16];
    logic [31:0] cmd_ts [16];
    logic [31:0] cyl_wr;
    logic [31:0] cyl_rep;
    bit          cyl_rep_ok;
    logic [31:0] th_ts [16];
    logic [31:0] th_bal [16];
    logic [31:0] th_set [16];
    logic [2:0]  unk_seen;
    frame_event_t pending_events [$];
    int          errors;
    int          matched;

    function new();
        stale_win = 20'd10000;
        echo_win = 20'd5000;
        unk_limit = 3'd5;
        for (int i = 0; i < 16; i++)
        begin
            cmd_pos[i] = 0; cmd_ok[i] = 0; rep_pos[i] = 0; rep_ok[i] = 0;
            cmd_ts[i] = 0; th_ts[i] = 0; th_bal[i] = 0; th_set[i] = 0;
        end
        cyl_wr = 0; cyl_rep = 0; cyl_rep_ok = 0; unk_seen = 0;
        errors = 0; matched = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [19:0] val);
        if (idx == cfec_pkg::RegStale) stale_win = val;
        else if (idx == cfec_pkg::RegEcho) echo_win = val;
        else if (idx == cfec_pkg::RegLimit) unk_limit = val[2:0];
    endfunction

    // classify one accepted frame and queue its expected event
    function void note_frame(logic [10:0] id, logic [3:0] len, logic [63:0] d,
                             logic [31:0] t);
        frame_event_t e;
        logic [3:0]  n;
        logic [10:0] grp;
        logic [7:0]  c;
        logic [31:0] p;
        longint      gap;
        bit          resp;
        e = '0;
        n = id[3:0];
        grp = id & cfec_pkg::GrpMask;
        if (grp == cfec_pkg::GrpFirstCmd)
        begin
            e.node = n;
            cmd_ts[n] = t;
            if (len >= 2)
            begin
                c = d[55:48];
                if (c == cfec_pkg::CmdSetPos && len >= 6)
                begin
                    p = d[47:16];
                    if (!cmd_ok[n] || p != cmd_pos[n])
                    begin
                        e.code = cfec_pkg::EV_SET_POS; e.value = p;
                        e.delta = cmd_ok[n] ? p - cmd_pos[n] : 0;
                        cmd_pos[n] = p; cmd_ok[n] = 1;
                    end
                end
                else if (c == cfec_pkg::CmdStart) e.code = cfec_pkg::EV_START;
                else if (c == cfec_pkg::CmdStop) e.code = cfec_pkg::EV_STOP;
                else if (c == cfec_pkg::CmdEnable && len >= 6)
                begin
                    e.code = cfec_pkg::EV_ENABLE; e.value = {24'd0, d[23:16]};
                end
            end
        end
        else if (grp == cfec_pkg::GrpFirstRep)
        begin
            e.node = n;
            if (len >= 5 && d[31:24] == cfec_pkg::RepPosMark)
            begin
                p = d[63:32];
                if (!rep_ok[n] || p != rep_pos[n])
                begin
                    e.code = cfec_pkg::EV_FEEDBACK; e.value = p;
                    e.delta = rep_ok[n] ? p - rep_pos[n] : 0;
                    rep_pos[n] = p; rep_ok[n] = 1;
                end
            end
            if ({32'd0, t} > {32'd0, cmd_ts[n]} + {44'd0, stale_win}) e.stale = 1;
        end
        else if (id == cfec_pkg::IdCylCmd || id == cfec_pkg::IdCylRep)
        begin
            p = {d[39:24], d[15:0]};
            c = d[55:48];
            if (len >= 2 && id == cfec_pkg::IdCylCmd)
            begin
                if (c == cfec_pkg::CylWrite)
                begin
                    if (len >= 8 && d[23:16] == cfec_pkg::CylWriteSub && p != cyl_wr)
                    begin
                        e.code = cfec_pkg::EV_CYL_WRITE; e.value = p;
                        e.delta = p - cyl_wr; cyl_wr = p;
                    end
                end
                else if (c == cfec_pkg::CylEnable && len >= 5)
                begin
                    e.code = cfec_pkg::EV_CYL_ENABLE; e.value = {16'd0, d[39:24]};
                end
            end
            else if (len >= 2)
            begin
                if (c == cfec_pkg::CylFeedback)
                begin
                    if (len >= 8 && (!cyl_rep_ok || p != cyl_rep))
                    begin
                        e.code = cfec_pkg::EV_CYL_FEEDBACK; e.value = p;
                        e.delta = cyl_rep_ok ? p - cyl_rep : 0;
                        cyl_rep = p; cyl_rep_ok = 1;
                    end
                end
                else if (c != cfec_pkg::CylAck)
                begin
                    e.code = cfec_pkg::EV_CYL_UNEXPECTED; e.value = {24'd0, c};
                end
            end
        end
        else if (grp == cfec_pkg::GrpThird)
        begin
            e.node = n;
            c = d[63:56];
            if (len >= 1)
            begin
                if (c == cfec_pkg::ThSet && len >= 7)
                begin
                    gap = longint'({32'd0, t}) - longint'({32'd0, th_ts[n]});
                    resp = th_ts[n] != 0 && gap < longint'({44'd0, echo_win}) &&
                           !th_bal[n][31] && th_bal[n] != 0;
                    if (!resp)
                    begin
                        p = {d[15:8], d[23:16], d[31:24], d[39:32]};
                        th_bal[n] += 1; th_ts[n] = t;
                        if (p != th_set[n])
                        begin
                            e.code = cfec_pkg::EV_RMD_SET; e.value = p;
                            e.delta = p - th_set[n]; th_set[n] = p;
                        end
                    end
                    else th_bal[n] -= 1;
                end
                else if (c == cfec_pkg::ThResp) th_bal[n] -= 1;
                else if (c == cfec_pkg::ThEnable)
                begin
                    e.code = cfec_pkg::EV_RMD_ENABLE; th_bal[n] += 1; th_ts[n] = t;
                end
            end
        end
        else if (id == cfec_pkg::IdEstop) e.code = cfec_pkg::EV_ESTOP;
        else
        begin
            if (unk_seen < unk_limit)
            begin
                e.code = cfec_pkg::EV_UNKNOWN; e.value = {21'd0, id};
            end
            if (unk_seen < 3'd7) unk_seen++;
        end
        pending_events.push_back(e);
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endfunction

    // compare one output beat with the oldest expected event
    function void check_beat(frame_event_t got);
        frame_event_t w;
        if (pending_events.size() == 0)
        begin
            report("unexpected beat", got.code, 0);
            return;
        end
        w = pending_events.pop_front();
        if (got.code != w.code) report("event_code", got.code, w.code);
        if (got.node != w.node) report("node", got.node, w.node);
        if (got.value != w.value) report("value", got.value, w.value);
        if (got.delta != w.delta) report("delta", got.delta, w.delta);
        if (got.stale != w.stale) report("stale_response", got.stale, w.stale);
        matched++;
    endfunction
endclass

module can_frame_event_classifier_core_test;
    import cfec_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [1:0] cfg_idx = 0;
    logic [19:0] cfg_data = 0;
    logic in_valid = 0;
    logic in_ready;
    logic [10:0] can_id = 0;
    logic [3:0] frame_length = 0;
    logic [63:0] data_bytes = 0;
    logic [31:0] timestamp_us = 0;
    logic out_valid;
    logic out_ready = 0;
    logic [3:0] event_code;
    logic [3:0] node;
    logic signed [31:0] value;
    logic signed [31:0] delta;
    logic stale_response;

    frame_event_board board;
    int cycles = 0;
    bit hold_off = 0;
    bit stim_done = 0;
    logic [31:0] now_us = 0;

    can_frame_event_classifier_core uut (.*);

    always #10 clk = ~clk;

    // beats are sampled at the rising edge
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && in_valid && in_ready)
            board.note_frame(can_id, frame_length, data_bytes, timestamp_us);
        if (rst_n && out_valid && out_ready)
            board.check_beat({event_code, node, value, delta, stale_response});
    end

    // receiver stalls at random, or fully while held off
    always @(negedge clk)
    begin
        if (hold_off) out_ready <= 0;
        else if ($urandom_range(0, 99) < 70 || stim_done) out_ready <= 1;
        else out_ready <= ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(0, 1);
    end

    // random gap, mostly short
    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) g = 0;
        repeat (g) @(negedge clk);
    endtask

    // offer one frame and wait for its acceptance
    task automatic send_frame(logic [10:0] id, logic [3:0] len, logic [63:0] d,
                              logic [31:0] t);
        in_valid = 1; can_id <= id; frame_length <= len;
        data_bytes <= d; timestamp_us <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic wait_drained();
        while (board.pending_events.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [19:0] val);
        cfg_we = 1; cfg_idx <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_we = 0;
        board.write_reg(idx, val);
    endtask

    // well-formed frame of a random kind, sometimes noise
    task automatic random_frame();
        logic [10:0] id;
        logic [3:0]  len;
        logic [63:0] d;
        logic [3:0]  n;
        n = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 2));
        d = {$urandom, $urandom};
        len = $urandom_range(0, 9) < 8 ? 4'd8 : 4'($urandom);
        now_us += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20000)
                                              : $urandom_range(0, 3000);
        if ($urandom_range(0, 40) == 0) now_us = $urandom;
        case ($urandom_range(0, 11))
            0, 1:
            begin
                id = GrpFirstCmd | n;
                d[55:48] = $urandom_range(0, 3) == 0 ? CmdStart :
                           $urandom_range(0, 2) == 0 ? CmdStop :
                           $urandom_range(0, 1) ? CmdSetPos : CmdEnable;
                if ($urandom_range(0, 2) == 0) d[47:16] = 32'($urandom_range(0, 3));
            end
            2, 3:
            begin
                id = GrpFirstRep | n;
                if ($urandom_range(0, 4) != 0) d[31:24] = RepPosMark;
                if ($urandom_range(0, 2) == 0) d[63:32] = 32'($urandom_range(0, 3));
            end
            4:
            begin
                id = IdCylCmd;
                d[55:48] = $urandom_range(0, 1) ? CylWrite : CylEnable;
                if ($urandom_range(0, 4) != 0) d[23:16] = CylWriteSub;
                if ($urandom_range(0, 2) == 0) {d[39:24], d[15:0]} = $urandom_range(0, 2);
            end
            5:
            begin
                id = IdCylRep;
                d[55:48] = $urandom_range(0, 2) != 0 ? CylFeedback :
                           $urandom_range(0, 1) ? CylAck : 8'($urandom);
                if ($urandom_range(0, 2) == 0) {d[39:24], d[15:0]} = $urandom_range(0, 2);
            end
            6, 7, 8:
            begin
                id = GrpThird | n;
                d[63:56] = $urandom_range(0, 2) != 0 ? ThSet :
                           $urandom_range(0, 1) ? ThResp : ThEnable;
                if ($urandom_range(0, 2) == 0) d[39:8] = 32'($urandom_range(0, 3));
            end
            9: id = IdEstop;
            default: id = 11'($urandom);
        endcase
        send_frame(id, len, d, now_us);
    endtask

    initial
    begin
        logic [63:0] d;
        int sent;
        int lim_cycles;
        board = new();
        repeat (6) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: every kind, field extremes, unknown limit, wrap, stale
        send_frame(GrpFirstCmd | 11'd0, 4'd6, 64'h0086_7FFF_FFFF_0000, 32'd100);
        send_frame(GrpFirstCmd | 11'd0, 4'd6, 64'h0086_8000_0000_0000, 32'd200);
        send_frame(GrpFirstCmd | 11'd0, 4'd6, 64'h0086_8000_0000_0000, 32'd300);
        send_frame(GrpFirstCmd | 11'd15, 4'd2, 64'h0083_0000_0000_0000, 32'd0);
        send_frame(GrpFirstCmd | 11'd1, 4'd8, 64'h0084_0000_0000_0000, 32'd0);
        send_frame(GrpFirstCmd | 11'd2, 4'd15, 64'h0001_0000_00FF_0000, 32'd5);
        send_frame(GrpFirstRep | 11'd0, 4'd5, 64'h1234_5678_3E00_0000, 32'd10300);
        send_frame(GrpFirstRep | 11'd0, 4'd5, 64'h1234_5678_3E00_0000, 32'd10301);
        send_frame(GrpFirstRep | 11'd15, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_frame(IdCylCmd, 4'd8, 64'h001A_00AB_CD05_EF01, 32'd1);
        send_frame(IdCylCmd, 4'd5, 64'h0000_00FF_FF00_0000, 32'd1);
        send_frame(IdCylRep, 4'd8, 64'h002B_0001_0200_0304, 32'd1);
        send_frame(IdCylRep, 4'd2, 64'h001B_0000_0000_0000, 32'd1);
        send_frame(IdCylRep, 4'd2, 64'h00FF_0000_0000_0000, 32'd1);
        send_frame(GrpThird | 11'd3, 4'd7, 64'hA400_0078_5634_1200, 32'd1000);
        send_frame(GrpThird | 11'd3, 4'd7, 64'hA400_0078_5634_1200, 32'd1500);
        send_frame(GrpThird | 11'd3, 4'd1, 64'h9200_0000_0000_0000, 32'd1600);
        send_frame(GrpThird | 11'd3, 4'd1, 64'h8800_0000_0000_0000, 32'd1700);
        send_frame(IdEstop, 4'd0, 64'd0, 32'd0);
        for (int i = 0; i < 7; i++)
            send_frame(11'h7A0 + 11'(i), 4'd0, 64'd0, 32'd0);
        wait_drained();

        // random phases under several register settings
        sent = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin write_reg(RegStale, 20'd0); write_reg(RegEcho, 20'd0);
                         write_reg(RegLimit, 3'd0); end
                1: begin write_reg(RegStale, 20'd1000000); write_reg(RegEcho, 20'd1000000);
                         write_reg(RegLimit, 3'd7); end
                2: begin write_reg(RegStale, 20'hFFFFF); write_reg(RegEcho, 20'hFFFFF); end
                default: begin write_reg(RegStale, 20'($urandom_range(0, 20000)));
                         write_reg(RegEcho, 20'($urandom_range(0, 10000)));
                         write_reg(RegLimit, 3'($urandom)); end
            endcase
            for (int k = 0; k < 270; k++)
            begin
                if (ph == 2 && k == 50)
                begin
                    // long receiver hold-off while frames keep coming
                    fork
                        begin
                            hold_off = 1;
                            lim_cycles = 0;
                            while (lim_cycles < 60) begin @(negedge clk); lim_cycles++; end
                            hold_off = 0;
                        end
                    join_none
                end
                if (k == 150) wait_drained();
                random_frame();
                sent++;
                if (hold_off == 0) idle_gap();
            end
            wait_drained();
        end
        stim_done = 1;
        wait_drained();
        $display("covered %0d frames and %0d result beats across six register settings",
                 sent + 26, board.matched);
        $display("all frame kinds, stalls on both sides and a full back-pressure stretch");
        if (board.errors == 0 && board.pending_events.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // guard against a hung handshake
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end
endmodule
`default_nettype wire

// File: files.f
rtl/cfec_pkg.sv
rtl/cfec_front.sv
rtl/cfec_back.sv
rtl/can_frame_event_classifier_core.sv
rtl/cfec_checker.sv
dv/can_frame_event_classifier_core_test.sv
